>>> rtl/tgmt_pkg.sv
// Package: shared types and constants of the gesture-to-pointer tracker.
`timescale 1ns / 1ps

package tgmt_pkg;

    localparam int unsigned CFG_DW = 16;
    localparam int unsigned CFG_AW = 2;

    // register indexes
    localparam logic [CFG_AW-1:0] CFG_PRESS   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_RELEASE = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_IDLE    = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_STEP    = 2'd3;

    localparam logic [7:0]  RST_PRESS   = 8'd50;
    localparam logic [7:0]  RST_RELEASE = 8'd90;
    localparam logic [15:0] RST_IDLE    = 16'd10000;
    localparam logic [6:0]  RST_STEP    = 7'd25;

    // gesture state / position codes
    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_RANGE  = 3'd1;
    localparam logic [2:0] ST_IDLE   = 3'd2;
    localparam logic [2:0] ST_MID    = 3'd3;
    localparam logic [2:0] ST_TOP    = 3'd4;
    localparam logic [2:0] ST_BOTTOM = 3'd5;
    localparam logic [2:0] ST_LEFT   = 3'd6;
    localparam logic [2:0] ST_RIGHT  = 3'd7;

    typedef struct packed {
        logic [7:0]  prs_thr;
        logic [7:0]  rel_thr;
        logic [15:0] idle_limit;
        logic [6:0]  move_step;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic sum;
        logic cmp;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

>>> rtl/tof_gesture_to_mouse_tracker.sv
// Top level of the proximity-gesture pointer tracker.
`timescale 1ns / 1ps

// Takes one four-sensor frame per transfer and returns exactly one pointer report per frame.
// A frame passes through capture, range sum, threshold compare and state commit in turn,
// stepped by the frame sequencer; the next frame is taken in the cycle after commit, so a
// new frame is not accepted until the previous one has committed, and commit waits while a
// previous report is still held in the output register.
// Configuration writes (index 0 press, 1 release, 2 idle limit, 3 move step) take effect
// at once and are meant for when no frame is in flight.

module tof_gesture_to_mouse_tracker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tgmt_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [tgmt_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_ready_top,
    input  logic [4:0]                  i_code_top,
    input  logic [7:0]                  i_range_top,
    input  logic                        i_ready_left,
    input  logic [4:0]                  i_code_left,
    input  logic [7:0]                  i_range_left,
    input  logic                        i_ready_bottom,
    input  logic [4:0]                  i_code_bottom,
    input  logic [7:0]                  i_range_bottom,
    input  logic                        i_ready_right,
    input  logic [4:0]                  i_code_right,
    input  logic [7:0]                  i_range_right,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_move_valid,
    output logic                        o_button_pressed,
    output logic signed [8:0]           o_delta_x,
    output logic signed [8:0]           o_delta_y,
    output logic [2:0]                  o_position,
    output logic                        o_asleep
);
    import tgmt_pkg::*;

    t_cfg       cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    tgmt_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tgmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tgmt_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_ready_top      (i_ready_top),
        .i_code_top       (i_code_top),
        .i_range_top      (i_range_top),
        .i_ready_left     (i_ready_left),
        .i_code_left      (i_code_left),
        .i_range_left     (i_range_left),
        .i_ready_bottom   (i_ready_bottom),
        .i_code_bottom    (i_code_bottom),
        .i_range_bottom   (i_range_bottom),
        .i_ready_right    (i_ready_right),
        .i_code_right     (i_code_right),
        .i_range_right    (i_range_right),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_move_valid     (o_move_valid),
        .o_button_pressed (o_button_pressed),
        .o_delta_x        (o_delta_x),
        .o_delta_y        (o_delta_y),
        .o_position       (o_position),
        .o_asleep         (o_asleep)
    );

endmodule

>>> rtl/tgmt_cfg_regs.sv
// Configuration register file of the tracker.
`timescale 1ns / 1ps

module tgmt_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tgmt_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [tgmt_pkg::CFG_DW-1:0] i_cfg_data,
    output tgmt_pkg::t_cfg             o_cfg
);
    import tgmt_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prs_thr    <= RST_PRESS;
            r_cfg.rel_thr    <= RST_RELEASE;
            r_cfg.idle_limit <= RST_IDLE;
            r_cfg.move_step  <= RST_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PRESS:   r_cfg.prs_thr    <= i_cfg_data[7:0];
                CFG_RELEASE: r_cfg.rel_thr    <= i_cfg_data[7:0];
                CFG_IDLE:    r_cfg.idle_limit <= i_cfg_data[15:0];
                CFG_STEP:    r_cfg.move_step  <= i_cfg_data[6:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/tgmt_ctrl.sv
// Frame sequencer: capture, sum, compare, commit.
`timescale 1ns / 1ps

module tgmt_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  tgmt_pkg::t_dp_status   i_status,
    output tgmt_pkg::t_dp_cmd      o_cmd
);
    import tgmt_pkg::*;

    localparam logic [1:0] S_WAIT = 2'd0;
    localparam logic [1:0] S_SUM  = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_WAIT: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                if (!i_status.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_WAIT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_WAIT;
        else          r_state <= n_state;
    end

    assign o_in_stall = (r_state != S_WAIT);

    a_load_then_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_SUM))
        else $error("capture not followed by sum");
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> !i_status.out_busy)
        else $error("commit into an occupied output");
    a_upd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) && i_status.out_busy |=> (r_state == S_UPD))
        else $error("left commit state while output busy");

endmodule

>>> rtl/tgmt_datapath.sv
// Datapath: frame capture, range sum, hysteresis compare, gesture state and output register.
`timescale 1ns / 1ps

module tgmt_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tgmt_pkg::t_cfg       i_cfg,
    input  tgmt_pkg::t_dp_cmd    i_cmd,
    output tgmt_pkg::t_dp_status o_status,
    input  logic                 i_ready_top,
    input  logic [4:0]           i_code_top,
    input  logic [7:0]           i_range_top,
    input  logic                 i_ready_left,
    input  logic [4:0]           i_code_left,
    input  logic [7:0]           i_range_left,
    input  logic                 i_ready_bottom,
    input  logic [4:0]           i_code_bottom,
    input  logic [7:0]           i_range_bottom,
    input  logic                 i_ready_right,
    input  logic [4:0]           i_code_right,
    input  logic [7:0]           i_range_right,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic                 o_move_valid,
    output logic                 o_button_pressed,
    output logic signed [8:0]    o_delta_x,
    output logic signed [8:0]    o_delta_y,
    output logic [2:0]           o_position,
    output logic                 o_asleep
);
    import tgmt_pkg::*;

    function automatic logic signed [2:0] coord_x(input logic [2:0] s);
        unique case (s)
            ST_LEFT:  coord_x = -3'sd1;
            ST_RIGHT: coord_x = 3'sd1;
            default:  coord_x = 3'sd0;
        endcase
    endfunction

    function automatic logic signed [2:0] coord_y(input logic [2:0] s);
        unique case (s)
            ST_TOP:    coord_y = -3'sd1;
            ST_BOTTOM: coord_y = 3'sd1;
            default:   coord_y = 3'sd0;
        endcase
    endfunction

    // captured frame: t, l, b, r detect bits
    logic       r_det_t, r_det_l, r_det_b, r_det_r;
    logic [7:0] r_rng_t, r_rng_l, r_rng_b, r_rng_r;
    logic [2:0] r_cnt_n;
    logic [9:0] r_sum;
    logic       r_prs_hit, r_rel_hit;

    // state
    logic [2:0]  r_gst;
    logic        r_btn;
    logic [15:0] r_empty;

    // output register
    logic              r_out_valid;
    logic              r_move_valid;
    logic signed [8:0] r_dx, r_dy;
    logic [2:0]        r_pos;

    logic [10:0] prs_lim;
    logic [11:0] rel_lim;
    logic [8:0]  rel_p1;

    logic              n_btn;
    logic [2:0]        n_gst;
    logic [15:0]       n_empty;
    logic              n_move;
    logic signed [8:0] n_dx, n_dy;
    logic              tgt_ok;
    logic [2:0]        tgt;
    logic signed [2:0] dfx, dfy;
    logic signed [11:0] prod_x, prod_y;
    logic              pos_st;

    assign o_status.out_busy = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_det_t <= i_ready_top    && (i_code_top    == 5'd0);
            r_det_l <= i_ready_left   && (i_code_left   == 5'd0);
            r_det_b <= i_ready_bottom && (i_code_bottom == 5'd0);
            r_det_r <= i_ready_right  && (i_code_right  == 5'd0);
            r_rng_t <= i_range_top;
            r_rng_l <= i_range_left;
            r_rng_b <= i_range_bottom;
            r_rng_r <= i_range_right;
        end
        if (i_cmd.sum) begin
            r_cnt_n <= 3'({2'b0, r_det_t} + {2'b0, r_det_l} + {2'b0, r_det_b}
                          + {2'b0, r_det_r});
            r_sum   <= (r_det_t ? {2'b0, r_rng_t} : 10'd0)
                     + (r_det_l ? {2'b0, r_rng_l} : 10'd0)
                     + (r_det_b ? {2'b0, r_rng_b} : 10'd0)
                     + (r_det_r ? {2'b0, r_rng_r} : 10'd0);
        end
        if (i_cmd.cmp) begin
            r_prs_hit <= ({1'b0, r_sum} < prs_lim);
            r_rel_hit <= ({2'b0, r_sum} >= rel_lim);
        end
    end

    // floor(sum/n) < P  <=>  sum < P*n ;  floor(sum/n) > R  <=>  sum >= (R+1)*n
    assign rel_p1  = {1'b0, i_cfg.rel_thr} + 9'd1;
    assign prs_lim = 11'({3'b0, i_cfg.prs_thr} * {8'b0, r_cnt_n});
    assign rel_lim = 12'({3'b0, rel_p1} * {9'b0, r_cnt_n});

    always_comb begin
        tgt_ok = 1'b1;
        tgt    = ST_MID;
        priority if (r_det_t && r_cnt_n == 3'd1) tgt = ST_TOP;
        else if (r_det_l && r_cnt_n == 3'd1)     tgt = ST_LEFT;
        else if (r_det_r && r_cnt_n == 3'd1)     tgt = ST_RIGHT;
        else if (r_det_b && r_cnt_n < 3'd3)      tgt = ST_BOTTOM;
        else if (r_cnt_n > 3'd2)                 tgt = ST_MID;
        else                                     tgt_ok = 1'b0;
    end

    assign pos_st = (r_gst != ST_INIT) && (r_gst != ST_RANGE) && (r_gst != ST_IDLE);
    assign dfx    = coord_x(tgt) - coord_x(r_gst);
    assign dfy    = coord_y(tgt) - coord_y(r_gst);
    assign prod_x = dfx * $signed({2'b0, i_cfg.move_step});
    assign prod_y = dfy * $signed({2'b0, i_cfg.move_step});

    always_comb begin
        n_btn   = r_btn;
        n_gst   = r_gst;
        n_empty = r_empty;
        n_move  = 1'b0;
        n_dx    = '0;
        n_dy    = '0;
        if (r_cnt_n != 3'd0) begin
            if (r_prs_hit && !r_btn)      n_btn = 1'b1;
            else if (r_rel_hit && r_btn)  n_btn = 1'b0;
        end
        if (r_gst == ST_INIT) begin
            n_btn = 1'b0;
            n_gst = ST_RANGE;
        end
        if (!pos_st) begin
            if (n_gst == ST_IDLE) begin
                if (r_cnt_n != 3'd0) n_empty = '0;
            end else if (r_cnt_n == 3'd0) begin
                if (r_empty > i_cfg.idle_limit) n_gst = ST_IDLE;
                else if (r_empty != 16'hFFFF)   n_empty = r_empty + 16'd1;
            end else begin
                n_empty = '0;
            end
            if (tgt_ok) n_gst = tgt;
        end else begin
            if (r_cnt_n == 3'd0) begin
                n_gst = ST_RANGE;
            end else if (tgt_ok && tgt != r_gst) begin
                n_move = 1'b1;
                n_dx   = prod_x[8:0];
                n_dy   = prod_y[8:0];
                n_gst  = tgt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gst   <= ST_INIT;
            r_btn   <= 1'b0;
            r_empty <= '0;
        end else if (i_cmd.commit) begin
            r_gst   <= n_gst;
            r_btn   <= n_btn;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_move_valid <= n_move;
            r_dx         <= n_dx;
            r_dy         <= n_dy;
            r_pos        <= n_gst;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_move_valid     = r_move_valid;
    assign o_button_pressed = r_btn;
    assign o_delta_x        = r_dx;
    assign o_delta_y        = r_dy;
    assign o_position       = r_pos;
    assign o_asleep         = (r_pos == ST_IDLE);

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("committed frame not presented");
    a_move_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_move_valid |-> (r_pos >= ST_MID))
        else $error("move reported outside a position");
    a_no_move_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_move_valid |-> (r_dx == 9'sd0) && (r_dy == 9'sd0))
        else $error("non-zero delta without a move");
    a_never_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_pos != ST_INIT) && (r_gst == r_pos))
        else $error("presented position disagrees with state");

endmodule
